/* hdl/sct_pkg.sv */
// Package for the S-expression character tokenizer.
// Holds character constants, status codes and the controller/datapath interface types.
// No dependencies; used by sct_ctrl, sct_datapath and sexpr_char_tokenizer.
package sct_pkg;

  localparam int unsigned MaxDepth = 31;
  localparam int unsigned CharW    = 8;
  localparam int unsigned StatusW  = 2;

  localparam logic [CharW-1:0] EndCharReset = 8'd59;  // ';'
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChNl     = 8'h0A;
  localparam logic [CharW-1:0] ChOpen   = 8'h28;
  localparam logic [CharW-1:0] ChClose  = 8'h29;
  localparam logic [CharW-1:0] ChQuote  = 8'h27;
  localparam logic [CharW-1:0] ChSqrClose = 8'h5D;

  localparam logic [StatusW-1:0] StNormal   = 2'd0;
  localparam logic [StatusW-1:0] StComplete = 2'd1;
  localparam logic [StatusW-1:0] StError    = 2'd2;

  // Configuration register indexes.
  localparam logic RegEndChar = 1'b0;

  typedef enum logic [2:0] {
    ClsEnd,
    ClsBlank,
    ClsOpen,
    ClsClose,
    ClsQuote,
    ClsBracket,
    ClsOther
  } cls_e;

  typedef enum logic [2:0] {
    EmitSpace,
    EmitChar,
    EmitRparen,
    EmitMarkOk,
    EmitMarkErr
  } emit_e;

  typedef enum logic [1:0] {
    DepthHold,
    DepthInc,
    DepthDec
  } depth_op_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_e     emit_sel;
    logic      emit_last;
    depth_op_e depth_op;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic last_was_space;
    logic depth_zero;
    logic depth_one;
    logic depth_full;
    logic out_free;
  } stat_t;

endpackage

/* hdl/sct_ctrl.sv */
// Controller state machine of the S-expression tokenizer.
// Sequences the result beats of one input character; depends on sct_pkg.
module sct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sct_pkg::stat_t stat_i,
  output sct_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSep  = 3'd1;
  localparam logic [2:0] StTok  = 3'd2;
  localparam logic [2:0] StTsp  = 3'd3;
  localparam logic [2:0] StMark = 3'd4;
  localparam logic [2:0] StRp   = 3'd5;
  localparam logic [2:0] StRsp  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  // A paren token is bad when it would overflow or underflow the depth.
  assign bad = ((stat_i.cls == sct_pkg::ClsOpen) && stat_i.depth_full) ||
               ((stat_i.cls == sct_pkg::ClsClose) && stat_i.depth_zero);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.emit_sel = sct_pkg::EmitSpace;
    cmd_o.depth_op = sct_pkg::DepthHold;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSep;
        end
      end
      StSep: begin
        unique case (stat_i.cls)
          sct_pkg::ClsEnd: begin
            if (!stat_i.depth_zero || stat_i.last_was_space) begin
              state_d = StMark;
            end else if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = StMark;
            end
          end
          sct_pkg::ClsBlank: begin
            if (stat_i.last_was_space) begin
              state_d = StIdle;
            end else if (stat_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              state_d         = StIdle;
            end
          end
          sct_pkg::ClsOpen, sct_pkg::ClsClose, sct_pkg::ClsQuote: begin
            if (stat_i.last_was_space) begin
              state_d = StTok;
            end else if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = StTok;
            end
          end
          sct_pkg::ClsBracket: begin
            if (stat_i.last_was_space) begin
              state_d = stat_i.depth_zero ? StIdle : StRp;
            end else if (stat_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = stat_i.depth_zero;
              state_d         = stat_i.depth_zero ? StIdle : StRp;
            end
          end
          default: begin
            state_d = StTok;
          end
        endcase
      end
      StTok: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = sct_pkg::EmitChar;
          cmd_o.emit_last = (stat_i.cls == sct_pkg::ClsOther);
          state_d         = (stat_i.cls == sct_pkg::ClsOther) ? StIdle : StTsp;
        end
      end
      StTsp: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = !bad;
          if (!bad && stat_i.cls == sct_pkg::ClsOpen) begin
            cmd_o.depth_op = sct_pkg::DepthInc;
          end else if (!bad && stat_i.cls == sct_pkg::ClsClose) begin
            cmd_o.depth_op = sct_pkg::DepthDec;
          end
          state_d = bad ? StMark : StIdle;
        end
      end
      StMark: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.restart   = 1'b1;
          cmd_o.emit_sel  = ((stat_i.cls == sct_pkg::ClsEnd) && stat_i.depth_zero) ?
                            sct_pkg::EmitMarkOk : sct_pkg::EmitMarkErr;
          state_d         = StIdle;
        end
      end
      StRp: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = sct_pkg::EmitRparen;
          state_d        = StRsp;
        end
      end
      StRsp: begin
        // Each closing space retires one open level.
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = stat_i.depth_one;
          cmd_o.depth_op  = sct_pkg::DepthDec;
          state_d         = stat_i.depth_one ? StIdle : StRp;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* hdl/sct_datapath.sv */
// Datapath of the S-expression tokenizer: character register, depth counter,
// space flag, end-character register and output register. Depends on sct_pkg.
module sct_datapath #(
  parameter int unsigned MAX_DEPTH = sct_pkg::MaxDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sct_pkg::CharW-1:0]    in_char_i,
  input  logic                         cfg_we_i,
  input  logic [sct_pkg::CharW-1:0]    cfg_wdata_i,
  output logic [sct_pkg::CharW-1:0]    end_char_o,
  input  sct_pkg::cmd_t                cmd_i,
  output sct_pkg::stat_t               stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [sct_pkg::CharW-1:0]    out_char_o,
  output logic                         has_char_o,
  output logic [sct_pkg::StatusW-1:0]  status_o,
  output logic                         last_o
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_DEPTH);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);

  logic [sct_pkg::CharW-1:0]   char_q, char_d;
  logic [sct_pkg::CharW-1:0]   end_char_q, end_char_d;
  logic [DepthW-1:0]           depth_q, depth_d;
  logic                        lws_q, lws_d;
  logic                        valid_q, valid_d;
  logic [sct_pkg::CharW-1:0]   ochar_q, ochar_d;
  logic                        ohas_q, ohas_d;
  logic [sct_pkg::StatusW-1:0] ost_q, ost_d;
  logic                        olast_q, olast_d;
  sct_pkg::cls_e               cls;

  // The end character wins over every other class.
  always_comb begin
    priority if (char_q == end_char_q) begin
      cls = sct_pkg::ClsEnd;
    end else if (char_q == sct_pkg::ChSpace || char_q == sct_pkg::ChNl ||
                 char_q == sct_pkg::ChTab) begin
      cls = sct_pkg::ClsBlank;
    end else if (char_q == sct_pkg::ChOpen) begin
      cls = sct_pkg::ClsOpen;
    end else if (char_q == sct_pkg::ChClose) begin
      cls = sct_pkg::ClsClose;
    end else if (char_q == sct_pkg::ChQuote) begin
      cls = sct_pkg::ClsQuote;
    end else if (char_q == sct_pkg::ChSqrClose) begin
      cls = sct_pkg::ClsBracket;
    end else begin
      cls = sct_pkg::ClsOther;
    end
  end

  assign stat_o.cls            = cls;
  assign stat_o.last_was_space = lws_q;
  assign stat_o.depth_zero     = (depth_q == '0);
  assign stat_o.depth_one      = (depth_q == DepthOne);
  assign stat_o.depth_full     = (depth_q >= DepthMax);
  assign stat_o.out_free       = !valid_q || out_ready_i;

  assign char_d     = cmd_i.load ? in_char_i : char_q;
  assign end_char_d = cfg_we_i ? cfg_wdata_i : end_char_q;

  always_comb begin
    ochar_d = ochar_q;
    ohas_d  = ohas_q;
    ost_d   = ost_q;
    olast_d = olast_q;
    lws_d   = lws_q;
    depth_d = depth_q;
    valid_d = valid_q && !out_ready_i;
    if (cmd_i.emit) begin
      valid_d = 1'b1;
      olast_d = cmd_i.emit_last;
      ohas_d  = 1'b1;
      ost_d   = sct_pkg::StNormal;
      unique case (cmd_i.emit_sel)
        sct_pkg::EmitSpace:  ochar_d = sct_pkg::ChSpace;
        sct_pkg::EmitChar:   ochar_d = char_q;
        sct_pkg::EmitRparen: ochar_d = sct_pkg::ChClose;
        sct_pkg::EmitMarkOk: begin
          ochar_d = '0;
          ohas_d  = 1'b0;
          ost_d   = sct_pkg::StComplete;
        end
        default: begin
          ochar_d = '0;
          ohas_d  = 1'b0;
          ost_d   = sct_pkg::StError;
        end
      endcase
      if (ohas_d) begin
        lws_d = (ochar_d == sct_pkg::ChSpace);
      end
    end
    unique case (cmd_i.depth_op)
      sct_pkg::DepthInc: depth_d = depth_q + DepthOne;
      sct_pkg::DepthDec: depth_d = depth_q - DepthOne;
      default:           depth_d = depth_q;
    endcase
    if (cmd_i.restart) begin
      lws_d   = 1'b1;
      depth_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_char_q <= sct_pkg::EndCharReset;
      depth_q    <= '0;
      lws_q      <= 1'b1;
      valid_q    <= 1'b0;
    end else begin
      end_char_q <= end_char_d;
      depth_q    <= depth_d;
      lws_q      <= lws_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    ochar_q <= ochar_d;
    ohas_q  <= ohas_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  assign end_char_o  = end_char_q;
  assign out_valid_o = valid_q;
  assign out_char_o  = ochar_q;
  assign has_char_o  = ohas_q;
  assign status_o    = ost_q;
  assign last_o      = olast_q;

endmodule

/* hdl/sexpr_char_tokenizer.sv */
// Top level of the S-expression character tokenizer.
// Instantiates sct_ctrl and sct_datapath and holds the APB register decode; uses sct_pkg.
//
// One raw character enters per beat on the s_axis channel. Each character yields zero
// or more result beats on the m_axis channel: normalised characters of a single-space
// separated token stream, plus marker beats (has_char low) reporting a complete
// expression or a paren mismatch. tlast marks the final beat caused by one character.
// The end character is set through the APB register at address 0 (reset value ';')
// and must be written only while the block is idle; the block does not enforce this.
// A separating space, when one is due, is the first result beat and is sent by the
// classification step; otherwise the first beat is sent by a later state.
// Throughput: one character at a time. A character passes through acceptance, then
// classification, which also sends any separating space, and then one state per result
// beat after that space; a ']' closing D open parens gives up to 2*D + 1 beats.
// A new character is taken once the last beat of the previous one is in the output
// register, even while that beat still waits for tready.
// When the receiver stalls, the output register holds its beat and the sequencer waits.
// Reset clears the paren depth, treats the stream as starting after a space, restores
// the end character and empties the output register.
module sexpr_char_tokenizer #(
  parameter int unsigned MAX_DEPTH = sct_pkg::MaxDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic [2:0]  m_axis_tuser_o,   // [0] has_char, [2:1] status
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  sct_pkg::cmd_t               cmd;
  sct_pkg::stat_t              stat;
  logic                        cfg_we;
  logic [sct_pkg::CharW-1:0]   end_char;
  logic [sct_pkg::CharW-1:0]   out_char;
  logic                        has_char;
  logic [sct_pkg::StatusW-1:0] status;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o &&
                    (paddr_i[2] == sct_pkg::RegEndChar);
  assign prdata_o = (paddr_i[2] == sct_pkg::RegEndChar) ? {24'd0, end_char} : 32'd0;

  sct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sct_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata_i[7:0]),
    .end_char_o  (end_char),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (out_char),
    .has_char_o  (has_char),
    .status_o    (status),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_char;
  assign m_axis_tuser_o = {status, has_char};

endmodule
